[src/sse_pkg.sv]
// shared types, codes and size table for the sprite scanline evaluation block
`timescale 1ns / 1ps
package sse_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_FRAME  = 2'd1;
  localparam logic [1:0] OP_LINE   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_INTERLACE  = 3'd0;
  localparam logic [2:0] REG_SIZE       = 3'd1;
  localparam logic [2:0] REG_SECOND_TBL = 3'd2;
  localparam logic [2:0] REG_TILE_BASE  = 3'd3;
  localparam logic [2:0] REG_TALL       = 3'd4;
  localparam logic [2:0] REG_DISP_OFF   = 3'd5;
  localparam logic [2:0] REG_ATTR_BASE  = 3'd6;
  localparam logic [2:0] REG_ROTATE     = 3'd7;

  // attribute store layout
  localparam int unsigned STORE_BYTES = 544;
  localparam int unsigned MAIN_BYTES  = 512;
  localparam int unsigned WORDS       = 128;

  // decoded sprite attributes
  typedef struct packed {
    logic [8:0] x;
    logic [7:0] y;
    logic [6:0] w;
    logic [6:0] h;
    logic [7:0] chr;
    logic       vflip;
    logic       hflip;
    logic [1:0] prio;
    logic [2:0] pal;
    logic       sel;
  } sprite_t;

  // one buffered tile fetch
  typedef struct packed {
    logic [8:0]  tile_x;
    logic [7:0]  fine_row;
    logic [1:0]  prio;
    logic [2:0]  pal;
    logic        hflip;
    logic [10:0] tile_number;
  } tile_t;

  // sprite width for a size mode and size select
  function automatic logic [6:0] dim_w(input logic [2:0] mode, input logic big);
    logic [6:0] r;
    case (mode)
      3'd0: r = big ? 7'd16 : 7'd8;
      3'd1: r = big ? 7'd32 : 7'd8;
      3'd2: r = big ? 7'd64 : 7'd8;
      3'd3: r = big ? 7'd32 : 7'd16;
      3'd4: r = big ? 7'd64 : 7'd16;
      3'd5: r = big ? 7'd64 : 7'd32;
      3'd6: r = big ? 7'd32 : 7'd16;
      default: r = big ? 7'd32 : 7'd16;
    endcase
    return r;
  endfunction

  // sprite height for a size mode and size select
  function automatic logic [6:0] dim_h(input logic [2:0] mode, input logic big);
    logic [6:0] r;
    case (mode)
      3'd0: r = big ? 7'd16 : 7'd8;
      3'd1: r = big ? 7'd32 : 7'd8;
      3'd2: r = big ? 7'd64 : 7'd8;
      3'd3: r = big ? 7'd32 : 7'd16;
      3'd4: r = big ? 7'd64 : 7'd16;
      3'd5: r = big ? 7'd64 : 7'd32;
      3'd6: r = big ? 7'd64 : 7'd32;
      default: r = 7'd32;
    endcase
    return r;
  endfunction

endpackage

[src/sprite_scanline_evaluation.sv]
// sprite scanline evaluation: attribute store, sprite picking and tile fetch generation
// write and frame items give no result
// a scanline item scans up to NUM_SPRITES entries at one per cycle via the store read port,
//   then expands each picked sprite into its tile columns, then shows each result
// one item at a time: in_stall stays high until the item's last result is taken
// reset: synchronous; a clearing pass zeroes all 128 attribute store words, input stalled
`timescale 1ns / 1ps
module sprite_scanline_evaluation #(
  parameter int NUM_SPRITES = 128,
  parameter int MAX_PICKED  = 32,
  parameter int MAX_TILES   = 34
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [9:0]  attr_address,
  input  logic [7:0]  attr_data,
  input  logic [8:0]  line_number,
  input  logic        odd_field,
  // result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tile_valid,
  output logic [8:0]  tile_x,
  output logic [7:0]  fine_row,
  output logic [1:0]  tile_priority,
  output logic [7:0]  palette_base,
  output logic        mirror_x,
  output logic [10:0] tile_number,
  output logic        last_of_line,
  output logic        sprite_overflow,
  output logic        tile_overflow,
  output logic [9:0]  internal_oam_address,
  output logic        address_valid
);
  import sse_pkg::*;

  localparam int CW  = $clog2(NUM_SPRITES + 1);
  localparam int PCW = $clog2(MAX_PICKED + 1);
  localparam int PIW = (MAX_PICKED > 1) ? $clog2(MAX_PICKED) : 1;
  localparam int NW  = $clog2(MAX_TILES + 1);
  localparam int TIW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_SCAN, S_LIST, S_ATTR, S_DEC, S_TILE, S_ORD, S_SHOW
  } state_t;

  state_t state;

  // configuration registers
  logic        interlace_mode;
  logic [2:0]  size_mode;
  logic [1:0]  second_table_select;
  logic [15:0] tile_table_base;
  logic        tall_screen;
  logic        display_off;
  logic [8:0]  attr_base_address;
  logic        rotation_enable;

  // memories and their read registers
  logic [31:0] attr_mem [WORDS];
  logic [7:0]  hi_mem [32];
  logic [6:0]  list_mem [MAX_PICKED];
  tile_t       tbuf [MAX_TILES];
  logic [31:0] attr_q;
  logic [7:0]  hi_q;
  logic [6:0]  list_q;
  tile_t       tb_q;

  // control and per-item state
  logic [6:0]     clr_cnt;
  logic [6:0]     first_idx;
  logic           rng_flag;
  logic           time_flag;
  logic [6:0]     s;
  logic [6:0]     s_prev;
  logic           ev;
  logic [CW-1:0]  cnt;
  logic [PCW-1:0] pc;
  logic [6:0]     last_pick;
  logic [PIW-1:0] k;
  logic [8:0]     line_q;
  logic           field_q;
  logic [NW-1:0]  n;
  logic [TIW-1:0] j;
  logic [9:0]     pick_addr;
  logic           addr_ok;

  // current sprite being expanded into tiles
  logic [8:0]  sp_x;
  logic [7:0]  sp_y;
  logic [3:0]  sp_tw;
  logic        sp_hflip;
  logic [1:0]  sp_prio;
  logic [2:0]  sp_pal;
  logic [10:0] sp_tbase;
  logic [3:0]  sp_chrx;
  logic [2:0]  tx;

  logic        in_acc;
  logic        attr_we;
  logic        hi_we;
  logic [6:0]  rd_addr;
  logic [6:0]  dec_idx;
  sprite_t     dec;
  logic        big;
  logic        covers;
  logic [6:0]  hgt;
  logic [9:0]  x_end;
  logic [8:0]  yh;
  logic [7:0]  last_line;
  logic        visible;
  logic        reload;
  logic [6:0]  first_next;
  logic        list_we;
  logic        pick_full;
  logic [7:0]  yd;
  logic [8:0]  yi;
  logic [8:0]  yv;
  logic [8:0]  yf;
  logic [15:0] base16;
  logic [3:0]  chry;
  logic [8:0]  sx;
  logic        skip;
  logic        last_tx;
  logic        tiles_full;
  logic [3:0]  mx;
  logic [3:0]  col;
  logic        tile_we;
  tile_t       tile_new;
  logic        is_last;
  logic        empty;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      interlace_mode      <= 1'b0;
      size_mode           <= '0;
      second_table_select <= '0;
      tile_table_base     <= '0;
      tall_screen         <= 1'b0;
      display_off         <= 1'b0;
      attr_base_address   <= '0;
      rotation_enable     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INTERLACE:  interlace_mode      <= cfg_data[0];
        REG_SIZE:       size_mode           <= cfg_data[2:0];
        REG_SECOND_TBL: second_table_select <= cfg_data[1:0];
        REG_TILE_BASE:  tile_table_base     <= cfg_data;
        REG_TALL:       tall_screen         <= cfg_data[0];
        REG_DISP_OFF:   display_off         <= cfg_data[0];
        REG_ATTR_BASE:  attr_base_address   <= cfg_data[8:0];
        REG_ROTATE:     rotation_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // store write decode
  assign attr_we = in_acc && (operation == OP_WRITE) && (attr_address < 10'(MAIN_BYTES));
  assign hi_we   = in_acc && (operation == OP_WRITE) && (attr_address >= 10'(MAIN_BYTES))
                   && (attr_address < 10'(STORE_BYTES));
  assign rd_addr = (state == S_SCAN) ? s : list_q;

  // main attribute store, four bytes per sprite in one word
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      attr_mem[clr_cnt] <= '0;
    end else if (attr_we) begin
      attr_mem[attr_address[8:2]][8*attr_address[1:0] +: 8] <= attr_data;
    end
    attr_q <= attr_mem[rd_addr];
  end

  // high table, two bits per sprite
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) hi_mem[i] <= '0;
    end else if (hi_we) begin
      hi_mem[attr_address[4:0]] <= attr_data;
    end
    hi_q <= hi_mem[rd_addr[6:2]];
  end

  // shared sprite decoder
  assign dec_idx = (state == S_SCAN) ? s_prev : list_q;
  always_comb begin
    big       = hi_q[{dec_idx[1:0], 1'b1}];
    dec.x     = {hi_q[{dec_idx[1:0], 1'b0}], attr_q[7:0]};
    dec.y     = attr_q[15:8] + 8'd1;
    dec.w     = dim_w(size_mode, big);
    dec.h     = dim_h(size_mode, big);
    if (size_mode >= 3'd6 && interlace_mode && !big) dec.h = 7'd16;
    dec.chr   = attr_q[23:16];
    dec.vflip = attr_q[31];
    dec.hflip = attr_q[30];
    dec.prio  = attr_q[29:28];
    dec.pal   = attr_q[27:25];
    dec.sel   = attr_q[24];
  end

  // line coverage test
  always_comb begin
    hgt    = interlace_mode ? {1'b0, dec.h[6:1]} : dec.h;
    x_end  = {1'b0, dec.x} + {3'b0, dec.w} - 10'd1;
    yh     = {1'b0, dec.y} + {2'b0, hgt};
    covers = 1'b0;
    if (!(dec.x > 9'd256 && x_end < 10'd512)) begin
      if (line_q >= {1'b0, dec.y} && line_q < yh) covers = 1'b1;
      if (yh >= 9'd256 && line_q < {1'b0, yh[7:0]}) covers = 1'b1;
    end
  end

  // line classification
  assign last_line  = tall_screen ? 8'd239 : 8'd224;
  assign visible    = (line_number >= 9'd1) && (line_number <= {1'b0, last_line});
  assign reload     = (line_number == {1'b0, last_line} + 9'd1) && !display_off;
  assign first_next = reload ? (rotation_enable ? attr_base_address[7:1] : 7'd0) : first_idx;

  // picked list
  assign pick_full = (pc >= PCW'(MAX_PICKED));
  assign list_we   = (state == S_SCAN) && ev && covers && !pick_full;
  always_ff @(posedge clk) begin
    if (list_we) list_mem[pc[PIW-1:0]] <= s_prev;
    list_q <= list_mem[k];
  end

  // row, character table and column setup for one sprite
  always_comb begin
    yd = line_q[7:0] - dec.y;
    yi = interlace_mode ? {yd, 1'b0} : {1'b0, yd};
    yv = yi;
    if (dec.vflip) begin
      if (dec.w == dec.h) yv = {2'b0, dec.h} - 9'd1 - yi;
      else if (yi < {2'b0, dec.w}) yv = {2'b0, dec.w} - 9'd1 - yi;
      else yv = 9'({2'b0, dec.w} * 2'd3) - 9'd1 - yi;
    end
    yf = yv;
    if (interlace_mode) yf = dec.vflip ? yv - {8'b0, field_q} : yv + {8'b0, field_q};
    base16 = tile_table_base;
    if (dec.sel) base16 = tile_table_base + 16'h2000 + {second_table_select, 14'b0} / 16'd2;
    chry = dec.chr[7:4] + yf[6:3];
  end

  // tile step
  assign sx         = sp_x + {3'b0, tx, 3'b0};
  assign skip       = (sp_x != 9'd256) && (sx >= 9'd256) && (sx <= 9'd504);
  assign last_tx    = ({1'b0, tx} == sp_tw - 4'd1);
  assign tiles_full = (n >= NW'(MAX_TILES));
  assign mx         = sp_hflip ? (sp_tw - 4'd1 - {1'b0, tx}) : {1'b0, tx};
  assign col        = sp_chrx + mx;
  assign tile_we    = (state == S_TILE) && !skip && !tiles_full;
  always_comb begin
    tile_new.tile_x      = sx;
    tile_new.fine_row    = sp_y;
    tile_new.prio        = sp_prio;
    tile_new.pal         = sp_pal;
    tile_new.hflip       = sp_hflip;
    tile_new.tile_number = sp_tbase + {7'b0, col};
  end

  // tile buffer
  always_ff @(posedge clk) begin
    if (tile_we) tbuf[n[TIW-1:0]] <= tile_new;
    tb_q <= tbuf[j];
  end

  assign empty   = (n == '0);
  assign is_last = empty || (NW'(j) + NW'(1) == n);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      first_idx <= '0;
      rng_flag  <= 1'b0;
      time_flag <= 1'b0;
      pc        <= '0;
      n         <= '0;
      j         <= '0;
      k         <= '0;
      ev        <= 1'b0;
      cnt       <= '0;
      pick_addr <= '0;
      addr_ok   <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 7'd1;
          if (clr_cnt == 7'(WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            case (operation)
              OP_FRAME: begin
                rng_flag  <= 1'b0;
                time_flag <= 1'b0;
              end
              OP_LINE: begin
                first_idx <= first_next;
                line_q    <= line_number;
                field_q   <= odd_field;
                n         <= '0;
                j         <= '0;
                if (visible) begin
                  s     <= first_next;
                  pc    <= '0;
                  cnt   <= '0;
                  ev    <= 1'b0;
                  state <= S_MOD;
                end else begin
                  pick_addr <= '0;
                  addr_ok   <= 1'b0;
                  state     <= S_ORD;
                end
              end
              default: ;
            endcase
          end
        end
        // wrap the first sprite into range
        S_MOD: begin
          if ({1'b0, s} >= 8'(NUM_SPRITES)) s <= 7'({1'b0, s} - 8'(NUM_SPRITES));
          else state <= S_SCAN;
        end
        // one sprite read and one coverage test per cycle
        S_SCAN: begin
          if ((ev && covers && pick_full) || (!ev && cnt == CW'(NUM_SPRITES))) begin
            if (ev) rng_flag <= 1'b1;
            ev <= 1'b0;
            if (pc == '0) begin
              pick_addr <= '0;
              addr_ok   <= 1'b0;
              state     <= S_ORD;
            end else begin
              pick_addr <= 10'h200 + {5'b0, last_pick[6:2]};
              addr_ok   <= 1'b1;
              k         <= PIW'(pc - PCW'(1));
              state     <= S_LIST;
            end
          end else begin
            if (ev && covers) begin
              pc        <= pc + PCW'(1);
              last_pick <= s_prev;
            end
            if (cnt < CW'(NUM_SPRITES)) begin
              s_prev <= s;
              s      <= ({1'b0, s} == 8'(NUM_SPRITES - 1)) ? 7'd0 : s + 7'd1;
              cnt    <= cnt + CW'(1);
              ev     <= 1'b1;
            end else begin
              ev <= 1'b0;
            end
          end
        end
        S_LIST: state <= S_ATTR;
        S_ATTR: state <= S_DEC;
        S_DEC: begin
          sp_x     <= dec.x;
          sp_y     <= yf[7:0];
          sp_tw    <= dec.w[6:3];
          sp_hflip <= dec.hflip;
          sp_prio  <= dec.prio;
          sp_pal   <= dec.pal;
          sp_chrx  <= dec.chr[3:0];
          sp_tbase <= base16[15:5] + {3'b0, chry, 4'b0};
          tx       <= '0;
          state    <= S_TILE;
        end
        // one tile column per cycle
        S_TILE: begin
          if (!skip && tiles_full) time_flag <= 1'b1;
          if (tile_we) n <= n + NW'(1);
          if ((!skip && tiles_full) || last_tx) begin
            if (k == '0) begin
              j     <= '0;
              state <= S_ORD;
            end else begin
              k     <= k - PIW'(1);
              state <= S_LIST;
            end
          end else begin
            tx <= tx + 3'd1;
          end
        end
        S_ORD: state <= S_SHOW;
        S_SHOW: begin
          if (!out_stall) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              j     <= j + TIW'(1);
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result outputs
  assign out_valid            = (state == S_SHOW);
  assign tile_valid           = !empty;
  assign tile_x               = empty ? '0 : tb_q.tile_x;
  assign fine_row             = empty ? '0 : tb_q.fine_row;
  assign tile_priority        = empty ? '0 : tb_q.prio;
  assign palette_base         = empty ? '0 : {1'b1, tb_q.pal, 4'b0};
  assign mirror_x             = empty ? 1'b0 : tb_q.hflip;
  assign tile_number          = empty ? '0 : tb_q.tile_number;
  assign last_of_line         = is_last;
  assign sprite_overflow      = rng_flag;
  assign tile_overflow        = time_flag;
  assign internal_oam_address = pick_addr;
  assign address_valid        = addr_ok;

  // checks
  a_no_result_when_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result shown while taking items");
  a_tile_bound: assert property (@(posedge clk) disable iff (rst)
    n <= NW'(MAX_TILES)) else $error("tile count beyond limit");
  a_pick_bound: assert property (@(posedge clk) disable iff (rst)
    pc <= PCW'(MAX_PICKED)) else $error("picked count beyond limit");
  a_line_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_line) |=> !out_valid)
    else $error("result after last of line");

endmodule

[sim/testbench.sv]
// self-checking testbench for the sprite scanline evaluation block
`timescale 1ns / 1ps
module testbench;
  import sse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE      = 800;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 21;

  // one result item as seen on the output ports
  typedef struct packed {
    logic        tv;
    logic [8:0]  tx;
    logic [7:0]  row;
    logic [1:0]  pri;
    logic [7:0]  pal;
    logic        mx;
    logic [10:0] tn;
    logic        last;
    logic        ro;
    logic        tov;
    logic [9:0]  addr;
    logic        av;
  } fetch_t;

  // decoded sprite in plain integers
  typedef struct {
    int unsigned x, y, w, h, chr, vflip, hflip, prio, pal, sel;
  } obj_attr_t;

  // one row of the directed table
  typedef struct packed {
    logic [1:0] op;
    logic [9:0] addr;
    logic [7:0] data;
    logic [8:0] line;
    logic       field;
    logic       typed;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [9:0]  attr_address;
  logic [7:0]  attr_data;
  logic [8:0]  line_number;
  logic        odd_field;
  logic        out_valid;
  logic        out_stall;
  logic        tile_valid;
  logic [8:0]  tile_x;
  logic [7:0]  fine_row;
  logic [1:0]  tile_priority;
  logic [7:0]  palette_base;
  logic        mirror_x;
  logic [10:0] tile_number;
  logic        last_of_line;
  logic        sprite_overflow;
  logic        tile_overflow;
  logic [9:0]  internal_oam_address;
  logic        address_valid;

  sprite_scanline_evaluation i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .attr_address(attr_address), .attr_data(attr_data), .line_number(line_number),
    .odd_field(odd_field),
    .out_valid(out_valid), .out_stall(out_stall), .tile_valid(tile_valid), .tile_x(tile_x),
    .fine_row(fine_row), .tile_priority(tile_priority), .palette_base(palette_base),
    .mirror_x(mirror_x), .tile_number(tile_number), .last_of_line(last_of_line),
    .sprite_overflow(sprite_overflow), .tile_overflow(tile_overflow),
    .internal_oam_address(internal_oam_address), .address_valid(address_valid)
  );

  // model state
  logic [7:0]  attr_mem_model [0:STORE_BYTES-1];
  int unsigned first_obj;
  bit          ro_flag, to_flag;
  int unsigned pick_list [0:31];
  int unsigned pick_n;
  int unsigned m_interlace, m_size, m_second, m_base, m_tall, m_dispoff, m_attrbase, m_rotate;

  fetch_t      fetch_q [$];
  fetch_t      tile_buf [$];
  stim_row_t   dir_tab [$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned focus_line;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run guard
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // sprite width and height pair of each size mode
  function automatic int unsigned obj_dim(int unsigned mode, int unsigned col);
    int unsigned t [4];
    case (mode)
      0: t = '{8, 16, 8, 16};
      1: t = '{8, 32, 8, 32};
      2: t = '{8, 64, 8, 64};
      3: t = '{16, 32, 16, 32};
      4: t = '{16, 64, 16, 64};
      5: t = '{32, 64, 32, 64};
      6: t = '{16, 32, 32, 64};
      default: t = '{16, 32, 32, 32};
    endcase
    return t[col];
  endfunction

  function automatic obj_attr_t decode_obj(int unsigned s);
    obj_attr_t d;
    int unsigned hi, sh, big, f, b;
    b   = (s & 127) << 2;
    hi  = attr_mem_model[512 + ((s >> 2) & 31)];
    sh  = (s & 3) << 1;
    big = (hi >> (sh + 1)) & 1;
    f   = attr_mem_model[b + 3];
    d.w = obj_dim(m_size, big);
    d.h = obj_dim(m_size, 2 + big);
    if (m_size >= 6 && m_interlace != 0 && big == 0) d.h = 16;
    d.x     = (((hi >> sh) & 1) << 8) | attr_mem_model[b];
    d.y     = (attr_mem_model[b + 1] + 1) & 255;
    d.chr   = attr_mem_model[b + 2];
    d.vflip = (f >> 7) & 1;
    d.hflip = (f >> 6) & 1;
    d.prio  = (f >> 4) & 3;
    d.pal   = (f >> 1) & 7;
    d.sel   = f & 1;
    return d;
  endfunction

  function automatic bit obj_on_line(obj_attr_t d, int unsigned line);
    int unsigned hgt;
    hgt = (m_interlace != 0) ? (d.h >> 1) : d.h;
    if (d.x > 256 && d.x + d.w - 1 < 512) return 1'b0;
    if (line >= d.y && line < d.y + hgt) return 1'b1;
    if (d.y + hgt >= 256 && line < ((d.y + hgt) & 255)) return 1'b1;
    return 1'b0;
  endfunction

  // tile columns of one sprite into the line buffer
  function automatic void fetch_obj_tiles(obj_attr_t d, int unsigned line, int unsigned field);
    int unsigned tw, x, y, base, chrx, chry, tx, sx, mcol, pos;
    fetch_t r;
    tw = d.w >> 3;
    x  = d.x & 511;
    y  = (line - d.y) & 255;
    if (m_interlace != 0) y = y << 1;
    if (d.vflip != 0) begin
      if (d.w == d.h) y = (d.h - 1) - y;
      else if (y < d.w) y = (d.w - 1) - y;
      else y = d.w + ((d.w - 1) - (y - d.w));
    end
    if (m_interlace != 0) y = (d.vflip != 0) ? y - field : y + field;
    y = y & 255;
    base = m_base & 16'hffff;
    if (d.sel != 0) base = (base + 8192 + (m_second << 13)) & 16'hffff;
    chrx = d.chr & 15;
    chry = (((d.chr >> 4) + (y >> 3)) & 15) << 4;
    for (tx = 0; tx < tw; tx++) begin
      sx = (x + (tx << 3)) & 511;
      if (x != 256 && sx >= 256 && sx + 7 < 512) continue;
      if (tile_buf.size() >= 34) begin
        to_flag = 1'b1;
        break;
      end
      mcol = (d.hflip != 0) ? (tw - 1) - tx : tx;
      pos  = base + ((chry + ((chrx + mcol) & 15)) << 5);
      r     = '0;
      r.tv  = 1'b1;
      r.tx  = sx[8:0];
      r.row = y[7:0];
      r.pri = d.prio[1:0];
      r.pal = 8'(128 + (d.pal << 4));
      r.mx  = d.hflip[0];
      r.tn  = 11'((pos >> 5) & 16'h07ff);
      tile_buf.push_back(r);
    end
  endfunction

  // expected results of one scanline item
  function automatic void predict_line(int unsigned line, int unsigned field);
    int unsigned last_line, i, s, addr, av;
    int k;
    obj_attr_t d;
    fetch_t r;
    addr = 0;
    av = 0;
    tile_buf.delete();
    last_line = (m_tall != 0) ? 239 : 224;
    if (line == last_line + 1 && m_dispoff == 0)
      first_obj = (m_rotate != 0) ? ((m_attrbase >> 1) & 127) : 0;
    if (line >= 1 && line <= last_line) begin
      pick_n = 0;
      for (i = 0; i < 128; i++) begin
        s = (i + first_obj) % 128;
        d = decode_obj(s);
        if (!obj_on_line(d, line)) continue;
        if (pick_n >= 32) begin
          ro_flag = 1'b1;
          break;
        end
        pick_list[pick_n] = s;
        pick_n++;
      end
      if (pick_n > 0) begin
        addr = 512 + (pick_list[pick_n - 1] >> 2);
        av = 1;
      end
      for (k = int'(pick_n) - 1; k >= 0; k--) begin
        d = decode_obj(pick_list[k]);
        fetch_obj_tiles(d, line, field);
      end
    end
    if (tile_buf.size() == 0) tile_buf.push_back('0);
    for (k = 0; k < tile_buf.size(); k++) begin
      r      = tile_buf[k];
      r.last = (k == tile_buf.size() - 1);
      r.ro   = ro_flag;
      r.tov  = to_flag;
      r.addr = addr[9:0];
      r.av   = av[0];
      fetch_q.push_back(r);
    end
  endfunction

  // model update for one accepted item
  function automatic void predict_item(stim_row_t it);
    case (it.op)
      OP_WRITE: if (it.addr < STORE_BYTES) attr_mem_model[it.addr] = it.data;
      OP_FRAME: begin
        ro_flag = 1'b0;
        to_flag = 1'b0;
      end
      OP_LINE: predict_line(it.line, it.field);
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_INTERLACE:  m_interlace = val & 1;
      REG_SIZE:       m_size = val & 7;
      REG_SECOND_TBL: m_second = val & 3;
      REG_TILE_BASE:  m_base = val;
      REG_TALL:       m_tall = val & 1;
      REG_DISP_OFF:   m_dispoff = val & 1;
      REG_ATTR_BASE:  m_attrbase = val & 511;
      REG_ROTATE:     m_rotate = val & 1;
      default: ;
    endcase
  endfunction

  function automatic void add_row(logic [1:0] op, logic [9:0] addr, logic [7:0] data,
                                  logic [8:0] line, logic field, logic typed);
    stim_row_t r;
    r.op = op; r.addr = addr; r.data = data; r.line = line; r.field = field; r.typed = typed;
    dir_tab.push_back(r);
  endfunction

  // offer one item, wait for acceptance, then an optional gap; entered and left at negedge
  task automatic send_item(stim_row_t it);
    int unsigned g, pick;
    operation    <= it.op;
    attr_address <= it.addr;
    attr_data    <= it.data;
    line_number  <= it.line;
    odd_field    <= it.field;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.typed) begin
      predict_item(it);
      // typed rows are empty lines with cleared flags
      void'(fetch_q.pop_back());
      fetch_q.push_back(fetch_t'{tv: 1'b0, tx: '0, row: '0, pri: '0, pal: '0, mx: 1'b0,
                                 tn: '0, last: 1'b1, ro: 1'b0, tov: 1'b0, addr: '0, av: 1'b0});
    end else begin
      predict_item(it);
    end
    @(negedge clk);
    pick = $urandom_range(0, 99);
    g = (pick < 65) ? 0 : (pick < 93) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // wait until the block is idle; entered and left at negedge
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fetch_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // one random item or a whole sprite of five writes, mostly sprites clustered around the focus line
  task automatic send_random();
    stim_row_t it;
    int unsigned pick, s, ll;
    pick = $urandom_range(0, 99);
    it = '0;
    it.field = 1'($urandom_range(0, 1));
    it.data = 8'($urandom_range(0, 255));
    it.line = 9'($urandom_range(0, 511));
    ll = (m_tall != 0) ? 239 : 224;
    if (pick < 45) begin
      // one sprite: x, y, character, flags, then its high byte
      s = $urandom_range(0, 127);
      it.op = OP_WRITE;
      it.addr = 10'(s << 2);
      it.data = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                8'($urandom_range(0, 200));
      send_item(it);
      it.addr = 10'((s << 2) + 1);
      it.data = 8'((focus_line - $urandom_range(0, 40)) & 255);
      send_item(it);
      it.addr = 10'((s << 2) + 2);
      it.data = 8'($urandom_range(0, 255));
      send_item(it);
      it.addr = 10'((s << 2) + 3);
      it.data = 8'($urandom_range(0, 255));
      send_item(it);
      it.addr = 10'(512 + (s >> 2));
      it.data = 8'($urandom_range(0, 255));
    end else if (pick < 82) begin
      it.op = OP_LINE;
      if (pick < 74) it.line = 9'((focus_line + $urandom_range(0, 24)) % (ll + 1));
      else if (pick < 78) it.line = 9'(ll + 1);
      if (pick == 50) focus_line = $urandom_range(1, ll);
    end else if (pick < 88) begin
      it.op = OP_FRAME;
    end else if (pick < 93) begin
      it.op = OP_UNUSED;
      it.addr = 10'($urandom_range(0, 1023));
    end else begin
      it.op = OP_WRITE;
      it.addr = 10'($urandom_range(512, 1023));
    end
    send_item(it);
  endtask

  // receiver stall pattern, with one long hold-off while items are on offer
  initial begin
    int unsigned run, pick;
    bit hold_done, st;
    out_stall = 1'b0;
    run = 0;
    hold_done = 1'b0;
    st = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && cycle_count > 1000 && in_valid) begin
        hold_done = 1'b1;
        st = 1'b1;
        run = 3000;
      end else if (run == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          st = 1'b0; run = $urandom_range(1, 20);
        end else if (pick < 8) begin
          st = 1'b1; run = $urandom_range(1, 3);
        end else if (pick < 9) begin
          st = 1'b1; run = $urandom_range(10, 40);
        end else begin
          st = 1'b0; run = $urandom_range(50, 200);
        end
      end
      run--;
      out_stall <= st;
    end
  end

  // result checker
  always @(posedge clk) begin
    fetch_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (fetch_q.size() == 0) begin
        $error("unexpected result item: tile_x %0d tile_number %0d", tile_x, tile_number);
        err_count++;
      end else begin
        exp_r = fetch_q.pop_front();
        if (tile_valid !== exp_r.tv) begin
          $error("tile_valid: expected %0d actual %0d", exp_r.tv, tile_valid); err_count++;
        end
        if (tile_x !== exp_r.tx) begin
          $error("tile_x: expected %0d actual %0d", exp_r.tx, tile_x); err_count++;
        end
        if (fine_row !== exp_r.row) begin
          $error("fine_row: expected %0d actual %0d", exp_r.row, fine_row); err_count++;
        end
        if (tile_priority !== exp_r.pri) begin
          $error("tile_priority: expected %0d actual %0d", exp_r.pri, tile_priority);
          err_count++;
        end
        if (palette_base !== exp_r.pal) begin
          $error("palette_base: expected %0d actual %0d", exp_r.pal, palette_base);
          err_count++;
        end
        if (mirror_x !== exp_r.mx) begin
          $error("mirror_x: expected %0d actual %0d", exp_r.mx, mirror_x); err_count++;
        end
        if (tile_number !== exp_r.tn) begin
          $error("tile_number: expected %0d actual %0d", exp_r.tn, tile_number); err_count++;
        end
        if (last_of_line !== exp_r.last) begin
          $error("last_of_line: expected %0d actual %0d", exp_r.last, last_of_line);
          err_count++;
        end
        if (sprite_overflow !== exp_r.ro) begin
          $error("sprite_overflow: expected %0d actual %0d", exp_r.ro, sprite_overflow);
          err_count++;
        end
        if (tile_overflow !== exp_r.tov) begin
          $error("tile_overflow: expected %0d actual %0d", exp_r.tov, tile_overflow);
          err_count++;
        end
        if (internal_oam_address !== exp_r.addr) begin
          $error("internal_oam_address: expected %0d actual %0d", exp_r.addr,
                 internal_oam_address);
          err_count++;
        end
        if (address_valid !== exp_r.av) begin
          $error("address_valid: expected %0d actual %0d", exp_r.av, address_valid);
          err_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    int unsigned p, n, i;
    err_count = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = '0;
    attr_address = '0;
    attr_data = '0;
    line_number = '0;
    odd_field = 1'b0;
    for (i = 0; i < STORE_BYTES; i++) attr_mem_model[i] = '0;
    first_obj = 0;
    ro_flag = 1'b0;
    to_flag = 1'b0;
    pick_n = 0;
    m_interlace = 0; m_size = 0; m_second = 0; m_base = 0;
    m_tall = 0; m_dispoff = 0; m_attrbase = 0; m_rotate = 0;
    focus_line = 100;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part: empty store puts every sprite on lines 1 to 8
    add_row(OP_LINE, 10'd0, 8'd0, 9'd0, 1'b0, 1'b1);
    add_row(OP_LINE, 10'd0, 8'd0, 9'd1, 1'b0, 1'b0);
    add_row(OP_FRAME, 10'd0, 8'd0, 9'd0, 1'b0, 1'b0);
    add_row(OP_LINE, 10'd0, 8'd0, 9'd0, 1'b1, 1'b1);
    add_row(OP_WRITE, 10'd20, 8'd255, 9'd0, 1'b0, 1'b0);
    add_row(OP_WRITE, 10'd21, 8'd100, 9'd0, 1'b0, 1'b0);
    add_row(OP_WRITE, 10'd22, 8'd255, 9'd0, 1'b0, 1'b0);
    add_row(OP_WRITE, 10'd23, 8'd255, 9'd0, 1'b0, 1'b0);
    add_row(OP_WRITE, 10'd513, 8'd255, 9'd0, 1'b0, 1'b0);
    add_row(OP_WRITE, 10'd543, 8'd255, 9'd0, 1'b0, 1'b0);
    add_row(OP_WRITE, 10'd544, 8'd255, 9'd0, 1'b0, 1'b0);
    add_row(OP_WRITE, 10'd1023, 8'd170, 9'd0, 1'b0, 1'b0);
    add_row(OP_UNUSED, 10'd1023, 8'd255, 9'd511, 1'b1, 1'b0);
    add_row(OP_LINE, 10'd0, 8'd0, 9'd101, 1'b1, 1'b0);
    add_row(OP_LINE, 10'd0, 8'd0, 9'd224, 1'b0, 1'b0);
    add_row(OP_LINE, 10'd0, 8'd0, 9'd225, 1'b0, 1'b0);
    add_row(OP_LINE, 10'd0, 8'd0, 9'd256, 1'b1, 1'b0);
    add_row(OP_LINE, 10'd0, 8'd0, 9'd511, 1'b1, 1'b0);
    add_row(OP_LINE, 10'd0, 8'd0, 9'd4, 1'b1, 1'b0);
    add_row(OP_FRAME, 10'd0, 8'd0, 9'd0, 1'b0, 1'b0);
    add_row(OP_LINE, 10'd0, 8'd0, 9'd300, 1'b0, 1'b1);
    foreach (dir_tab[j]) send_item(dir_tab[j]);

    // random phases, each with its own register setting
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(REG_INTERLACE,  (p == 0) ? 16'd1 : (p == 1) ? 16'd0 : 16'($urandom_range(0, 1)));
      write_reg(REG_SIZE,       (p == 0) ? 16'd7 : (p == 1) ? 16'd3 : 16'($urandom_range(0, 7)));
      write_reg(REG_SECOND_TBL, (p == 0) ? 16'd3 : (p == 1) ? 16'd0 : 16'($urandom_range(0, 3)));
      write_reg(REG_TILE_BASE,  (p == 0) ? 16'hffff : (p == 1) ? 16'd0 :
                                16'($urandom_range(0, 65535)));
      write_reg(REG_TALL,       (p == 0) ? 16'd1 : (p == 1) ? 16'd0 : 16'($urandom_range(0, 1)));
      write_reg(REG_DISP_OFF,   (p == 1) ? 16'd1 : 16'd0);
      write_reg(REG_ATTR_BASE,  (p == 0) ? 16'd511 : (p == 1) ? 16'd0 :
                                16'($urandom_range(0, 511)));
      write_reg(REG_ROTATE,     (p == 1) ? 16'd0 : 16'd1);
      for (n = 0; n < PHASE_ITEMS; n++) send_random();
    end

    // drain
    in_valid <= 1'b0;
    while (fetch_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (err_count == 0 && fetch_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
